// ===== design/dual_beam_direction_counter_core_assert.svh =====
// Assertion macros used by the checker file of the direction counter
`ifndef DUAL_BEAM_DIRECTION_COUNTER_CORE_ASSERT_SVH
`define DUAL_BEAM_DIRECTION_COUNTER_CORE_ASSERT_SVH

// Antecedent in this cycle, consequent from the next cycle on
`define DBDC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dbdc: next-cycle check failed");

// Antecedent and consequent in the same cycle
`define DBDC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dbdc: same-cycle check failed");

`endif

// ===== design/dbdc_pkg.sv =====
// Types, constants and codes of the dual-beam direction counter
package dbdc_pkg;

    // Lane count; the lane field and mask limit the usable lanes to four
    localparam int LANES  = 4;
    localparam int MASK_W = 4;
    localparam int NL     = (LANES < MASK_W) ? LANES : MASK_W;
    localparam int IDX_W  = (NL > 1) ? $clog2(NL) : 1;

    localparam int CMD_W   = 2;
    localparam int LANE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'd65535;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_BEAM_A = 2'd0,
        CMD_BEAM_B = 2'd1,
        CMD_SNAP   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_code_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_MIN_TRANS  = 3'd1,
        REG_MAX_TRANS  = 3'd2,
        REG_STUCK      = 3'd3,
        REG_REFRACTORY = 3'd4,
        REG_LANE_MASK  = 3'd5
    } cfg_reg_t;

    // Per-lane detection mode
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_A_FIRST = 2'd1,
        MODE_B_FIRST = 2'd2,
        MODE_COOL    = 2'd3
    } lane_mode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input transfer
        logic check;    // time checks of a beam event, clear sweep state
        logic update;   // apply a beam event
        logic sweep;    // process one lane of a snapshot
        logic load;     // load the result register
    } dbdc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_beam;
        logic is_snap;
        logic last_lane;
        logic out_free;
    } dbdc_stat_t;

endpackage

// ===== design/dbdc_ifs.sv =====
// Valid/ready channel interfaces for events and snapshot results

interface dbdc_req_if;
    logic                            valid;
    logic                            ready;
    logic [dbdc_pkg::CMD_W-1:0]      cmd;
    logic [dbdc_pkg::LANE_W-1:0]     lane;
    logic [dbdc_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, output cmd, output lane, output now_ms, input ready);
    modport sink   (input valid, input cmd, input lane, input now_ms, output ready);
endinterface

interface dbdc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [dbdc_pkg::CNT_W-1:0]      total_in;
    logic [dbdc_pkg::CNT_W-1:0]      total_out;
    logic [dbdc_pkg::MASK_W-1:0]     stuck_lanes;
    logic [dbdc_pkg::TIME_W-1:0]     interval_ms;
    logic [dbdc_pkg::MASK_W-1:0]     enabled_lanes;

    modport source (output valid, output total_in, output total_out, output stuck_lanes,
                    output interval_ms, output enabled_lanes, input ready);
    modport sink   (input valid, input total_in, input total_out, input stuck_lanes,
                    input interval_ms, input enabled_lanes, output ready);
endinterface

// ===== design/dbdc_datapath.sv =====
// Datapath: configuration, lane state, time checks, snapshot sweep, result register
module dbdc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dbdc_pkg::dbdc_cmd_t             cmd,
    output dbdc_pkg::dbdc_stat_t            stat,
    input  logic [dbdc_pkg::CMD_W-1:0]      in_cmd,
    input  logic [dbdc_pkg::LANE_W-1:0]     in_lane,
    input  logic [dbdc_pkg::TIME_W-1:0]     in_now,
    input  logic                            cfg_we,
    input  logic [dbdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbdc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [dbdc_pkg::CNT_W-1:0]      out_total_in,
    output logic [dbdc_pkg::CNT_W-1:0]      out_total_out,
    output logic [dbdc_pkg::MASK_W-1:0]     out_stuck,
    output logic [dbdc_pkg::TIME_W-1:0]     out_period,
    output logic [dbdc_pkg::MASK_W-1:0]     out_enabled
);

    localparam int NL    = dbdc_pkg::NL;
    localparam int IDX_W = dbdc_pkg::IDX_W;
    localparam int TW    = dbdc_pkg::TIME_W;
    localparam int CW    = dbdc_pkg::CNT_W;
    localparam int MW    = dbdc_pkg::MASK_W;

    // Configuration registers
    logic [dbdc_pkg::CFG_W-1:0] debounce_reg, min_trans_reg, max_trans_reg;
    logic [dbdc_pkg::CFG_W-1:0] stuck_time_reg, refr_reg;
    logic [MW-1:0]              mask_reg;

    // Latched input item
    logic [dbdc_pkg::CMD_W-1:0]  cmd_reg;
    logic [dbdc_pkg::LANE_W-1:0] lane_reg;
    logic [TW-1:0]               now_reg;

    // Lane state
    dbdc_pkg::lane_mode_t mode_reg [NL];
    dbdc_pkg::lane_mode_t mode_next [NL];
    logic [TW-1:0] last_a_reg [NL], last_a_next [NL];
    logic [TW-1:0] last_b_reg [NL], last_b_next [NL];
    logic [TW-1:0] entered_reg [NL], entered_next [NL];
    logic [CW-1:0] in_cnt_reg [NL], in_cnt_next [NL];
    logic [CW-1:0] out_cnt_reg [NL], out_cnt_next [NL];
    logic [NL-1:0] stuck_reg, stuck_next;

    // Check stage results and snapshot accumulators
    logic          deb_ok_reg, deb_ok_next;
    logic          trans_ok_reg, trans_ok_next;
    logic [IDX_W-1:0] sw_idx_reg, sw_idx_next;
    logic [CW-1:0] acc_in_reg, acc_in_next;
    logic [CW-1:0] acc_out_reg, acc_out_next;
    logic [MW-1:0] acc_stuck_reg, acc_stuck_next;
    logic [TW-1:0] snap_time_reg;

    // Result register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] res_in_reg, res_out_reg;
    logic [MW-1:0] res_stuck_reg, res_en_reg;
    logic [TW-1:0] res_period_reg;

    // Event lane decode
    logic [IDX_W-1:0] ev_idx;
    logic             ev_on;
    logic             is_b;
    logic [TW-1:0]    last_sel;
    logic [TW-1:0]    deb_diff;
    logic [TW-1:0]    transit;

    // Sweep lane decode
    logic             sw_on;
    logic [TW-1:0]    elapsed;
    logic             sw_wait;
    logic             sw_stuck_new;
    logic [CW:0]      sum_in, sum_out;

    assign ev_idx = lane_reg[IDX_W-1:0];
    assign ev_on  = (int'(lane_reg) < NL) && mask_reg[lane_reg];
    assign is_b   = (cmd_reg == dbdc_pkg::CMD_BEAM_B);

    assign stat.is_beam   = (cmd_reg == dbdc_pkg::CMD_BEAM_A) || is_b;
    assign stat.is_snap   = (cmd_reg == dbdc_pkg::CMD_SNAP);
    assign stat.last_lane = (sw_idx_reg == IDX_W'(NL - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Debounce and transit window for the event lane
    assign last_sel      = is_b ? last_b_reg[ev_idx] : last_a_reg[ev_idx];
    assign deb_diff      = now_reg - last_sel;
    assign transit       = now_reg - entered_reg[ev_idx];
    assign deb_ok_next   = cmd.check ? (deb_diff >= TW'(debounce_reg)) : deb_ok_reg;
    assign trans_ok_next = cmd.check ? ((transit >= TW'(min_trans_reg)) &&
                                        (transit <= TW'(max_trans_reg))) : trans_ok_reg;

    // Timeout, stuck and cooldown checks for the swept lane
    assign sw_on        = mask_reg[sw_idx_reg];
    assign elapsed      = now_reg - entered_reg[sw_idx_reg];
    assign sw_wait      = (mode_reg[sw_idx_reg] == dbdc_pkg::MODE_A_FIRST) ||
                          (mode_reg[sw_idx_reg] == dbdc_pkg::MODE_B_FIRST);
    assign sw_stuck_new = sw_wait && (elapsed > TW'(stuck_time_reg));
    assign sum_in       = {1'b0, acc_in_reg} + {1'b0, in_cnt_reg[sw_idx_reg]};
    assign sum_out      = {1'b0, acc_out_reg} + {1'b0, out_cnt_reg[sw_idx_reg]};

    // Lane state next values
    always_comb
    begin
        stuck_next = stuck_reg;
        for (int i = 0; i < NL; i++)
        begin
            mode_next[i]    = mode_reg[i];
            last_a_next[i]  = last_a_reg[i];
            last_b_next[i]  = last_b_reg[i];
            entered_next[i] = entered_reg[i];
            in_cnt_next[i]  = in_cnt_reg[i];
            out_cnt_next[i] = out_cnt_reg[i];

            // beam event
            if (cmd.update && ev_on && deb_ok_reg && (ev_idx == IDX_W'(i)))
            begin
                if (is_b)
                    last_b_next[i] = now_reg;
                else
                    last_a_next[i] = now_reg;
                if (mode_reg[i] == dbdc_pkg::MODE_IDLE)
                begin
                    mode_next[i]    = is_b ? dbdc_pkg::MODE_B_FIRST : dbdc_pkg::MODE_A_FIRST;
                    entered_next[i] = now_reg;
                end
                else if (mode_reg[i] == (is_b ? dbdc_pkg::MODE_A_FIRST
                                              : dbdc_pkg::MODE_B_FIRST))
                begin
                    if (trans_ok_reg)
                    begin
                        if (is_b && (in_cnt_reg[i] != dbdc_pkg::COUNT_MAX))
                            in_cnt_next[i] = in_cnt_reg[i] + CW'(1);
                        if (!is_b && (out_cnt_reg[i] != dbdc_pkg::COUNT_MAX))
                            out_cnt_next[i] = out_cnt_reg[i] + CW'(1);
                    end
                    mode_next[i]    = dbdc_pkg::MODE_COOL;
                    entered_next[i] = now_reg;
                end
            end

            // snapshot sweep of one lane
            if (cmd.sweep && sw_on && (sw_idx_reg == IDX_W'(i)))
            begin
                if (sw_wait && (elapsed > TW'(max_trans_reg)))
                    mode_next[i] = dbdc_pkg::MODE_IDLE;
                if ((mode_reg[i] == dbdc_pkg::MODE_COOL) && (elapsed >= TW'(refr_reg)))
                    mode_next[i] = dbdc_pkg::MODE_IDLE;
                in_cnt_next[i]  = '0;
                out_cnt_next[i] = '0;
                stuck_next[i]   = 1'b0;
            end
        end
    end

    // Sweep counter and accumulators
    always_comb
    begin
        sw_idx_next    = sw_idx_reg;
        acc_in_next    = acc_in_reg;
        acc_out_next   = acc_out_reg;
        acc_stuck_next = acc_stuck_reg;
        if (cmd.check)
        begin
            sw_idx_next    = '0;
            acc_in_next    = '0;
            acc_out_next   = '0;
            acc_stuck_next = '0;
        end
        else if (cmd.sweep)
        begin
            sw_idx_next = sw_idx_reg + IDX_W'(1);
            if (sw_on)
            begin
                acc_in_next  = sum_in[CW]  ? dbdc_pkg::COUNT_MAX : sum_in[CW-1:0];
                acc_out_next = sum_out[CW] ? dbdc_pkg::COUNT_MAX : sum_out[CW-1:0];
                for (int i = 0; i < NL; i++)
                begin
                    if ((sw_idx_reg == IDX_W'(i)) && (stuck_reg[i] || sw_stuck_new))
                        acc_stuck_next[i] = 1'b1;
                end
            end
        end
    end

    assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= 16'd3;
            min_trans_reg  <= 16'd10;
            max_trans_reg  <= 16'd1000;
            stuck_time_reg <= 16'd10000;
            refr_reg       <= 16'd50;
            mask_reg       <= 4'hF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dbdc_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                dbdc_pkg::REG_MIN_TRANS:  min_trans_reg  <= cfg_data;
                dbdc_pkg::REG_MAX_TRANS:  max_trans_reg  <= cfg_data;
                dbdc_pkg::REG_STUCK:      stuck_time_reg <= cfg_data;
                dbdc_pkg::REG_REFRACTORY: refr_reg       <= cfg_data;
                dbdc_pkg::REG_LANE_MASK:  mask_reg       <= cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // Input item latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_cmd;
            lane_reg <= in_lane;
            now_reg  <= in_now;
        end
    end

    // Lane state, sweep and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                mode_reg[i]    <= dbdc_pkg::MODE_IDLE;
                last_a_reg[i]  <= '0;
                last_b_reg[i]  <= '0;
                entered_reg[i] <= '0;
                in_cnt_reg[i]  <= '0;
                out_cnt_reg[i] <= '0;
            end
            stuck_reg     <= '0;
            snap_time_reg <= '0;
            out_valid_reg <= 1'b0;
            sw_idx_reg    <= '0;
        end
        else
        begin
            for (int i = 0; i < NL; i++)
            begin
                mode_reg[i]    <= mode_next[i];
                last_a_reg[i]  <= last_a_next[i];
                last_b_reg[i]  <= last_b_next[i];
                entered_reg[i] <= entered_next[i];
                in_cnt_reg[i]  <= in_cnt_next[i];
                out_cnt_reg[i] <= out_cnt_next[i];
            end
            stuck_reg     <= stuck_next;
            if (cmd.load)
                snap_time_reg <= now_reg;
            out_valid_reg <= out_valid_next;
            sw_idx_reg    <= sw_idx_next;
        end
    end

    // Check results, accumulators and result payload
    always_ff @(posedge clk)
    begin
        deb_ok_reg    <= deb_ok_next;
        trans_ok_reg  <= trans_ok_next;
        acc_in_reg    <= acc_in_next;
        acc_out_reg   <= acc_out_next;
        acc_stuck_reg <= acc_stuck_next;
        if (cmd.load)
        begin
            res_in_reg     <= acc_in_reg;
            res_out_reg    <= acc_out_reg;
            res_stuck_reg  <= acc_stuck_reg;
            res_period_reg <= now_reg - snap_time_reg;
            res_en_reg     <= mask_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_total_in  = res_in_reg;
    assign out_total_out = res_out_reg;
    assign out_stuck     = res_stuck_reg;
    assign out_period    = res_period_reg;
    assign out_enabled   = res_en_reg;

endmodule

// ===== design/dbdc_ctrl.sv =====
// Controller: sequences capture, event checks, event update, snapshot sweep and result load
module dbdc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dbdc_pkg::dbdc_stat_t  stat,
    output dbdc_pkg::dbdc_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.is_beam)
                    state_next = ST_UPDATE;
                else if (stat.is_snap)
                    state_next = ST_SWEEP;
                else
                    state_next = ST_IDLE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.last_lane)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/dual_beam_direction_counter_core.sv =====
// Top level of the dual-beam direction counter: controller plus datapath
//
//  channel  dir  handshake       payload
//  req      in   valid / ready   cmd, lane, now_ms
//  rsp      out  valid / ready   total_in, total_out, stuck_lanes, interval_ms, enabled_lanes
//  cfg      in   cfg_we          cfg_index, cfg_data
//
// A beam event passes through transfer, time checks and lane update; an unused command ends after the checks.
// A snapshot passes through transfer and checks, then the sweep visits one lane per cycle through a
// single check-and-accumulate unit, then the result register is loaded.
// The result register frees the input side; a snapshot waits in its last step only
// while the previous result has not been taken. Reset is asynchronous, active low.
module dual_beam_direction_counter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    dbdc_req_if.sink                        req,
    dbdc_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [dbdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbdc_pkg::CFG_W-1:0]      cfg_data
);

    dbdc_pkg::dbdc_cmd_t  cmd;
    dbdc_pkg::dbdc_stat_t stat;
    logic                 in_ready;

    assign req.ready = in_ready;

    // Sequencer
    dbdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Lane state and arithmetic
    dbdc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_cmd        (req.cmd),
        .in_lane       (req.lane),
        .in_now        (req.now_ms),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .out_total_in  (rsp.total_in),
        .out_total_out (rsp.total_out),
        .out_stuck     (rsp.stuck_lanes),
        .out_period    (rsp.interval_ms),
        .out_enabled   (rsp.enabled_lanes)
    );

endmodule

// ===== design/dbdc_checker.sv =====
// Port-level checker of the direction counter and its bind
`include "dual_beam_direction_counter_core_assert.svh"

module dbdc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic [dbdc_pkg::CMD_W-1:0]   req_cmd,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [dbdc_pkg::CNT_W-1:0]   rsp_total_in,
    input logic [dbdc_pkg::CNT_W-1:0]   rsp_total_out,
    input logic [dbdc_pkg::MASK_W-1:0]  rsp_stuck_lanes,
    input logic [dbdc_pkg::TIME_W-1:0]  rsp_interval_ms,
    input logic [dbdc_pkg::MASK_W-1:0]  rsp_enabled_lanes
);

    logic acc_work;
    logic acc_beam;

    assign acc_work = req_valid && req_ready &&
                      ((req_cmd == dbdc_pkg::CMD_BEAM_A) || (req_cmd == dbdc_pkg::CMD_BEAM_B) ||
                       (req_cmd == dbdc_pkg::CMD_SNAP));
    assign acc_beam = req_valid && req_ready &&
                      ((req_cmd == dbdc_pkg::CMD_BEAM_A) || (req_cmd == dbdc_pkg::CMD_BEAM_B));

    // a real command keeps the input closed after its transfer
    `DBDC_ASSERT_NEXT(a_busy_after_transfer, acc_work, !req_ready ##1 !req_ready)

    // a beam event never produces a result
    `DBDC_ASSERT_NEXT(a_beam_no_result, acc_beam, !$rose(rsp_valid) ##1 !$rose(rsp_valid))

    // only enabled lanes can be reported stuck
    `DBDC_ASSERT_NOW(a_stuck_in_mask, rsp_valid, (rsp_stuck_lanes & ~rsp_enabled_lanes) == '0)

    // a stalled result stays put
    `DBDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_total_in) && $stable(rsp_total_out) &&
        $stable(rsp_interval_ms) && $stable(rsp_stuck_lanes))

endmodule

bind dual_beam_direction_counter_core dbdc_checker u_dbdc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_cmd           (req.cmd),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_total_in      (rsp.total_in),
    .rsp_total_out     (rsp.total_out),
    .rsp_stuck_lanes   (rsp.stuck_lanes),
    .rsp_interval_ms   (rsp.interval_ms),
    .rsp_enabled_lanes (rsp.enabled_lanes)
);
